FILE: rtl/core/rcun_pkg.sv
package rcun_pkg;
    localparam int MAX_LEN_DEF     = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEN_BITS        = 7;
    localparam int OUT_BITS        = 16;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd64;
endpackage

FILE: rtl/core/rcun_if.sv
interface rcun_in_if #(parameter int SAMPLE_BITS = rcun_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_row;
    modport source (output valid, sample, final_row, input ready);
    modport sink   (input valid, sample, final_row, output ready);
endinterface

interface rcun_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rcun_pkg::OUT_BITS-1:0] normalized;
    logic                                 row_end;
    logic                                 matrix_end;
    logic                                 flat_row;
    modport source (output valid, normalized, row_end, matrix_end, flat_row, input ready);
    modport sink   (input valid, normalized, row_end, matrix_end, flat_row, output ready);
endinterface

FILE: rtl/core/row_center_unit_norm.sv
// Row mean-centering and unit-norm normalization.
// Input channel i_in carries one sample word per accepted handshake; the
// register row_length (written via i_cfg_we/i_cfg_wdata; write it only while idle, which
// the block does not enforce) sets the samples per row (0 acts as 1, above MAX_LEN as MAX_LEN).
// Samples load at one per cycle into a row memory with one write and one read
// port, and a running sum. After the last sample of a row, input stops (default widths):
//   mean: serial divide, NUMW = 34 quotient bits
//   sum of squares: one memory read per sample
//   square root: one result bit per cycle, RW = 30 result bits
//   emit: each sample is re-read and divided by the norm bit-serially,
//   QW = 43 quotient bits per result word.
// Output o_out holds each result word until taken; a receiver stall simply
// freezes the emit pass. Input resumes once the last word of the row is taken.
// Results carry row_end on the last word, matrix_end on the last word when
// any sample of the row had final_row set, and flat_row (with zero data)
// when the row norm is zero.
// Reset (synchronous, active low) clears the fill count, sum and control
// state and restores row_length to 64; the row memory is not cleared.
module row_center_unit_norm #(
    parameter int MAX_LEN     = rcun_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = rcun_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rcun_pkg::LEN_BITS-1:0] i_cfg_wdata,
    rcun_in_if.sink                       i_in,
    rcun_out_if.source                    o_out
);
    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int SB  = SAMPLE_BITS + CW + 1;        // sum width
    localparam int NUMW = SB + 10;                     // sum*512 + n
    localparam int DW  = SAMPLE_BITS + 10;             // |d| Q8 magnitude
    localparam int SSW = 2 * DW + CW;                  // sum of squares
    localparam int RW  = (SSW + 1) / 2;                // root width
    localparam int QW  = DW + 17;                      // dividend 2*ad<<15 + norm
    localparam int OW  = rcun_pkg::OUT_BITS;

    localparam logic [3:0] S_LOAD = 4'd0, S_MEAN = 4'd1, S_SSRD = 4'd2,
                           S_SQRT = 4'd3, S_ERD = 4'd4, S_EDIV = 4'd5,
                           S_EOUT = 4'd6, S_MFIX = 4'd7;

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_LEN];
    logic signed [SAMPLE_BITS-1:0] r_rd;

    logic [rcun_pkg::LEN_BITS-1:0] r_len;
    logic [3:0]                    r_st;
    logic [CW-1:0]                 r_fill, r_k;
    logic signed [SB-1:0]          r_sum;
    logic                          r_last;
    logic [$clog2(2*NUMW+2)-1:0]   r_cnt;
    logic [NUMW-1:0]               r_num, r_q;
    logic [NUMW:0]                 r_rem;
    logic                          r_neg;
    logic signed [NUMW:0]          r_mean;
    logic [SSW-1:0]                r_ss;
    logic [RW-1:0]                 r_root;
    logic                          r_rdv, r_dneg;
    logic [QW-1:0]                 r_dq, r_qq;
    logic [RW+1:0]                 r_drem;
    logic signed [OW-1:0]          r_res;
    logic                          r_ov, r_oend, r_ofl;

    // effective length
    logic [CW-1:0] eff_len;
    always_comb begin
        if (r_len == '0) eff_len = CW'(1);
        else if (32'(r_len) > MAX_LEN) eff_len = CW'(MAX_LEN);
        else eff_len = CW'(r_len);
    end

    assign i_in.ready = (r_st == S_LOAD);
    wire in_acc = i_in.valid && i_in.ready;
    wire wrap   = (32'(r_fill) >= MAX_LEN);
    wire [CW-1:0] fill_b = wrap ? '0 : r_fill;
    wire [AW-1:0] rd_addr = r_k[AW-1:0];

    // deviation of stored sample
    logic signed [NUMW+1:0] dev;
    logic [DW-1:0]          adev;
    always_comb begin
        dev  = ($signed({{(NUMW+2-SAMPLE_BITS){r_rd[SAMPLE_BITS-1]}}, r_rd}) <<< 8)
               - {r_mean[NUMW], r_mean};
        adev = dev[NUMW+1] ? DW'(-dev) : DW'(dev);
    end

    logic [NUMW:0] rem_sh;
    assign rem_sh = {r_rem[NUMW-1:0], r_num[NUMW-1]};
    logic [SSW-1:0] tr;
    logic [2*RW-1:0] tsq;
    assign tr  = SSW'(r_root | (RW'(1) << r_cnt));
    assign tsq = (2*RW)'(tr) * (2*RW)'(tr);
    logic [RW+1:0] drs;
    assign drs = {r_drem[RW:0], r_dq[QW-1]};

    always_ff @(posedge i_clk) begin
        if (in_acc) r_mem[fill_b[AW-1:0]] <= i_in.sample;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= rcun_pkg::LEN_RESET;
            r_st <= S_LOAD; r_fill <= '0; r_sum <= '0; r_last <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
            r_fill <= '0; r_sum <= '0; r_last <= 1'b0;
        end else begin
            unique case (r_st)
                S_LOAD: if (in_acc) begin
                    r_fill <= fill_b + CW'(1);
                    if (wrap) begin
                        r_sum  <= SB'(i_in.sample);
                        r_last <= i_in.final_row;
                    end else begin
                        r_sum  <= r_sum + SB'(i_in.sample);
                        r_last <= r_last | i_in.final_row;
                    end
                    if (fill_b + CW'(1) >= eff_len) begin
                        // floor((sum*512+n)/(2n)) via magnitude divide
                        logic signed [NUMW:0] num;
                        num = (wrap ? (NUMW+1)'(i_in.sample)
                                    : (NUMW+1)'(r_sum + SB'(i_in.sample))) <<< 9;
                        num = num + (NUMW+1)'(fill_b + CW'(1));
                        r_neg <= num[NUMW];
                        r_num <= num[NUMW] ? NUMW'(-num) : NUMW'(num);
                        r_rem <= '0; r_q <= '0; r_cnt <= '0;
                        r_st <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (rem_sh >= (NUMW+1)'({r_fill, 1'b0})) begin
                        r_rem <= rem_sh - (NUMW+1)'({r_fill, 1'b0});
                        r_q <= {r_q[NUMW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_q <= {r_q[NUMW-2:0], 1'b0};
                    end
                    r_num <= {r_num[NUMW-2:0], 1'b0};
                    if (32'(r_cnt) == NUMW-1) r_st <= S_MFIX;
                    else r_cnt <= r_cnt + 1'b1;
                end
                S_MFIX: begin
                    // negative: floor = -(q + (rem!=0))
                    if (r_neg) r_mean <= -$signed({1'b0, r_q}) - ((r_rem != 0) ? 1 : 0);
                    else r_mean <= $signed({1'b0, r_q});
                    r_ss <= '0; r_k <= '0; r_rdv <= 1'b0; r_st <= S_SSRD;
                end
                S_SSRD: begin
                    if (r_rdv) r_ss <= r_ss + SSW'((2*DW)'(adev) * (2*DW)'(adev));
                    r_rdv <= (r_k < r_fill);
                    if (r_k < r_fill) r_k <= r_k + CW'(1);
                    else if (!r_rdv) begin
                        r_root <= '0; r_cnt <= $bits(r_cnt)'(RW-1); r_st <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (SSW'(tsq) <= r_ss && (2*RW)'(tsq) <= (2*RW)'(r_ss))
                        r_root <= RW'(tr);
                    if (r_cnt == '0) begin
                        r_k <= '0; r_st <= S_ERD;
                    end else r_cnt <= r_cnt - 1'b1;
                end
                S_ERD: begin
                    r_st <= S_EDIV;
                    r_rdv <= 1'b0;
                end
                S_EDIV: begin
                    if (!r_rdv) begin
                        r_dneg <= dev[NUMW+1];
                        r_dq <= (QW'(adev) << 16) + QW'(r_root);
                        r_drem <= '0; r_qq <= '0; r_cnt <= '0; r_rdv <= 1'b1;
                    end else begin
                        if (drs >= {r_root, 1'b0}) begin
                            r_drem <= drs - {r_root, 1'b0};
                            r_qq <= {r_qq[QW-2:0], 1'b1};
                        end else begin
                            r_drem <= drs;
                            r_qq <= {r_qq[QW-2:0], 1'b0};
                        end
                        r_dq <= {r_dq[QW-2:0], 1'b0};
                        if (32'(r_cnt) == QW-1) r_st <= S_EOUT;
                        else r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_EOUT: begin
                    if (!r_ov) begin
                        if (r_root == '0) r_res <= '0;
                        else if (r_dneg)
                            r_res <= (r_qq > QW'(32768)) ? -16'sd32768 : OW'(-r_qq);
                        else r_res <= (r_qq > QW'(32767)) ? 16'sd32767 : OW'(r_qq);
                        r_oend <= (r_k + CW'(1) == r_fill);
                        r_ofl <= (r_root == '0);
                        r_ov <= 1'b1;
                    end else if (o_out.ready) begin
                        r_ov <= 1'b0;
                        if (r_oend) begin
                            r_fill <= '0; r_sum <= '0; r_last <= 1'b0;
                            r_st <= S_LOAD;
                        end else begin
                            r_k <= r_k + CW'(1); r_st <= S_ERD;
                        end
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.normalized = r_res;
    assign o_out.row_end    = r_oend;
    assign o_out.matrix_end = r_oend & r_last;
    assign o_out.flat_row   = r_ofl;
endmodule

FILE: tb/rcun_norm_check.sv
module rcun_norm_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rcun_pkg::LEN_BITS-1:0] i_cfg_wdata,
    rcun_in_if                            i_in,
    rcun_out_if                           i_out,
    output int                            o_errors,
    output int                            o_words_left,
    output int                            o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_MAX = rcun_pkg::MAX_LEN_DEF;

    typedef struct {
        logic signed [rcun_pkg::OUT_BITS-1:0] normalized;
        logic                                 row_end;
        logic                                 matrix_end;
        logic                                 flat_row;
    } norm_word_t;

    norm_word_t                                      expected_words[$];
    logic signed [rcun_pkg::SAMPLE_BITS_DEF-1:0]     row_buf[ROW_MAX];
    logic [rcun_pkg::LEN_BITS-1:0]                   row_len;
    int                                              fill;
    longint                                          acc;
    bit                                              last_seen;

    function automatic int eff_len(logic [rcun_pkg::LEN_BITS-1:0] len);
        if (len == 0) return 1;
        if (len > ROW_MAX) return ROW_MAX;
        return int'(len);
    endfunction

    // Mean in Q8 rounded half up, norm = floor(sqrt(sum of squared deviations)).
    task automatic normalize_row();
        longint                num, den, mean, d;
        longint unsigned       ss, root, t, ad, mag;
        norm_word_t            w;
        num = acc * 512 + fill;
        den = 2 * fill;
        mean = num / den;
        if ((num % den) != 0 && num < 0) mean--;
        ss = 0;
        for (int k = 0; k < fill; k++) begin
            d = longint'(row_buf[k]) * 256 - mean;
            ad = d < 0 ? -d : d;
            ss += ad * ad;
        end
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            t = root | (64'd1 << b);
            if (t * t <= ss) root = t;
        end
        for (int k = 0; k < fill; k++) begin
            w.normalized = '0;
            if (root != 0) begin
                d = longint'(row_buf[k]) * 256 - mean;
                ad = d < 0 ? -d : d;
                mag = (2 * (ad << 15) + root) / (2 * root);
                if (d < 0) w.normalized = mag > 32768 ? -16'sd32768 : -16'(mag);
                else       w.normalized = mag > 32767 ? 16'sd32767 : 16'(mag);
            end
            w.row_end    = (k + 1 == fill);
            w.matrix_end = (k + 1 == fill) && last_seen;
            w.flat_row   = (root == 0);
            expected_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        norm_word_t exp_w;
        if (!i_rst_n) begin
            row_len   <= rcun_pkg::LEN_RESET;
            fill      = 0;
            acc       = 0;
            last_seen = 0;
            expected_words.delete();
            o_errors        <= 0;
            o_words_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                row_len   <= i_cfg_wdata;
                fill      = 0;
                acc       = 0;
                last_seen = 0;
            end
            if (i_in.valid && i_in.ready) begin
                row_buf[fill] = i_in.sample;
                fill++;
                acc += longint'(i_in.sample);
                if (i_in.final_row) last_seen = 1;
                if (fill >= eff_len(row_len)) begin
                    normalize_row();
                    fill      = 0;
                    acc       = 0;
                    last_seen = 0;
                end
            end
            if (i_out.valid && i_out.ready) begin
                o_words_checked <= o_words_checked + 1;
                if (expected_words.size() == 0) begin
                    $display("%t unexpected result word: %0d row_end %b matrix_end %b flat %b",
                             $realtime, i_out.normalized, i_out.row_end, i_out.matrix_end,
                             i_out.flat_row);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.normalized !== i_out.normalized || exp_w.row_end !== i_out.row_end
                        || exp_w.matrix_end !== i_out.matrix_end
                        || exp_w.flat_row !== i_out.flat_row) begin
                        $display("%t mismatch: expected %0d/%b/%b/%b actual %0d/%b/%b/%b",
                                 $realtime, exp_w.normalized, exp_w.row_end, exp_w.matrix_end,
                                 exp_w.flat_row, i_out.normalized, i_out.row_end,
                                 i_out.matrix_end, i_out.flat_row);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_words_left <= expected_words.size();
    end
endmodule

FILE: tb/tb_row_center_unit_norm.sv
module tb_row_center_unit_norm;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [rcun_pkg::LEN_BITS-1:0] cfg_wdata;
    int                            errors, words_left, words_checked;
    int                            sent, settings_done;

    rcun_in_if  in_ch ();
    rcun_out_if out_ch ();

    row_center_unit_norm u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    rcun_norm_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_errors        (errors),
        .o_words_left    (words_left),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[row_center_unit_norm] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // receiver: random stalls, one long hold-off once 150 words have been checked
    initial begin
        int hold, gap;
        bit held_once, steady;
        hold = 0;
        held_once = 0;
        steady = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held_once && words_checked >= 150) begin
                held_once = 1;
                hold = 600;
            end
            if ($urandom_range(0, 199) == 0) steady = ~steady;
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else if (steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    hold = gap - 1;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_word(logic signed [15:0] s, logic fr, bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= s;
        in_ch.final_row <= fr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_and_set(logic [rcun_pkg::LEN_BITS-1:0] len);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_left != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        settings_done++;
    endtask

    function automatic logic signed [15:0] pick_sample(int mode, logic signed [15:0] base);
        case (mode)
            0: return 16'($urandom);
            1: return base + 16'($urandom_range(0, 20)) - 16'sd10;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return base;
        endcase
    endfunction

    initial begin
        logic [rcun_pkg::LEN_BITS-1:0] lens[12] = '{7'd64, 7'd4, 7'd0, 7'd100, 7'd7, 7'd2,
                                                   7'd127, 7'd3, 7'd16, 7'd1, 7'd5, 7'd9};
        int n, rows, mode;
        bit burst;
        logic signed [15:0] base;
        sent = 0;
        settings_done = 0;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample    <= '0;
        in_ch.final_row <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length one: every word is its own flat row
        drain_and_set(7'd1);
        send_word(16'sh8000, 1'b0, 0);
        send_word(16'sh7fff, 1'b1, 0);
        send_word(16'sd0, 1'b0, 0);
        // length two: extremes, flat pair, rounding ties
        drain_and_set(7'd2);
        send_word(16'sh8000, 1'b0, 0);
        send_word(16'sh7fff, 1'b0, 0);
        send_word(16'sd5, 1'b1, 0);
        send_word(16'sd5, 1'b0, 0);
        send_word(16'sd1, 1'b0, 0);
        send_word(16'sd2, 1'b0, 0);
        send_word(-16'sd1, 1'b0, 1);
        send_word(-16'sd2, 1'b1, 1);
        // length three, then a partial row dropped by the next write
        drain_and_set(7'd3);
        send_word(16'sd1, 1'b0, 0);
        send_word(16'sd0, 1'b0, 0);
        send_word(16'sd0, 1'b0, 0);
        send_word(16'sh8000, 1'b0, 0);
        send_word(16'sh8000, 1'b0, 0);
        send_word(16'sh7fff, 1'b1, 0);
        send_word(16'sd9, 1'b1, 0);
        send_word(-16'sd9, 1'b0, 0);

        while (sent < 400) begin
            foreach (lens[i]) begin
                drain_and_set(lens[i]);
                n = lens[i] == 0 ? 1 : (lens[i] > 64 ? 64 : int'(lens[i]));
                rows = n >= 16 ? 1 : (22 + n - 1) / n;
                for (int r = 0; r < rows; r++) begin
                    mode = $urandom_range(0, 9);
                    mode = mode < 5 ? 0 : (mode < 7 ? 1 : (mode < 8 ? 2 : 3));
                    base = 16'($urandom);
                    burst = ($urandom_range(0, 3) == 0);
                    // once, wait with the input until the output has caught up
                    if (i == 4 && r == 2) begin
                        in_ch.valid <= 1'b0;
                        @(posedge i_clk);
                        while (words_left != 0) @(posedge i_clk);
                    end
                    for (int k = 0; k < n; k++)
                        send_word(pick_sample(mode, base), $urandom_range(0, 5) == 0, burst);
                end
                // now and then leave a partial row behind
                if (n > 1 && $urandom_range(0, 2) == 0)
                    send_word(16'($urandom), 1'b1, 0);
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_left != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);
        $display("Sent %0d samples over %0d row length settings, %0d result words compared.",
                 sent, settings_done, words_checked);
        if (errors == 0 && words_left == 0) begin
            $display("[row_center_unit_norm] OK");
        end else begin
            $display("[row_center_unit_norm] ERROR");
        end
        $finish;
    end
endmodule
